// File: rtl/active_set_rank_list_macros.svh
// Assertion macros used by the asrl_chk checker.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef ACTIVE_SET_RANK_LIST_MACROS_SVH
`define ACTIVE_SET_RANK_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASRL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("asrl_chk: property violated");

// The consequent must hold in the cycle after the antecedent.
`define ASRL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("asrl_chk: property violated");

`endif

// File: rtl/asrl_pkg.sv
`timescale 1ns / 1ps

package asrl_pkg;

	// Sizing of the element space and the memories.
	localparam int MAX_ELEMENTS = 1024;
	localparam int DEPTH        = MAX_ELEMENTS + 1;
	localparam int AW           = $clog2(DEPTH);
	localparam int W            = 11;

	typedef logic [W-1:0]  elem_t;
	typedef logic [AW-1:0] addr_t;

	// Command codes.
	typedef enum logic [1:0] {
		CMD_RESTART = 2'd0,
		CMD_QUERY   = 2'd1,
		CMD_DEACT   = 2'd2,
		CMD_SPARE   = 2'd3
	} cmd_t;

	// One entry of the element-indexed memory.
	typedef struct packed {
		elem_t prev;
		elem_t next;
		elem_t rank;
	} link_t;

	localparam int LW = $bits(link_t);

	// Memory port requests.
	typedef struct packed {
		logic  en;
		addr_t addr;
	} rd_req_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		link_t data;
	} a_wr_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		elem_t data;
	} b_wr_t;

	// One result item.
	typedef struct packed {
		logic  element_active;
		elem_t predecessor;
		elem_t successor;
		logic  has_predecessor;
		logic  has_successor;
		elem_t element_rank;
		elem_t first_active;
		elem_t active_total;
		elem_t element_at_rank;
		logic  error;
	} result_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_DE_RD,
		ST_DE_CHK,
		ST_P_RD,
		ST_P_WR,
		ST_WALK,
		ST_WTAIL,
		ST_FLUSH,
		ST_RPT_RD,
		ST_RPT
	} state_t;

	// Element value to memory address.
	function automatic addr_t to_addr(elem_t v);
		return addr_t'(v);
	endfunction

endpackage

// File: rtl/asrl_ram.sv
`timescale 1ns / 1ps

module asrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/asrl_seq.sv
`timescale 1ns / 1ps

module asrl_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       cmd,
	input  asrl_pkg::elem_t  element,
	input  asrl_pkg::elem_t  rank_index,
	input  asrl_pkg::elem_t  element_count,
	input  logic             slot_free,
	output logic             rslt_valid,
	output asrl_pkg::result_t rslt,
	output asrl_pkg::rd_req_t a_rd,
	output asrl_pkg::a_wr_t  a_wr,
	input  asrl_pkg::link_t  a_rdata,
	output asrl_pkg::rd_req_t b_rd,
	output asrl_pkg::b_wr_t  b_wr,
	input  asrl_pkg::elem_t  b_rdata
);

	import asrl_pkg::*;

	state_t state_q, state_d;

	// Control registers.
	addr_t sw_q;
	elem_t n_q;
	elem_t head_q;
	elem_t live_q;
	logic  have_q;
	logic  rd_vld_s1;

	// Payload registers.
	elem_t e_q, r_q, p_q, s_q, rk_q, old_q, i_q;
	elem_t cur_q, curprev_q, cur_rank_q;
	elem_t rd_idx_s1;
	logic  err_q;

	logic  accept;
	elem_t cnt_sat;
	logic  e_in_rng;
	logic  r_ok;
	logic  e_act;
	logic  sw_last;
	elem_t sw_v;
	logic  sw_in;
	link_t sw_link;

	assign accept = in_valid && in_ready;

	// Decoded conditions.
	always_comb begin
		cnt_sat  = (element_count > elem_t'(MAX_ELEMENTS)) ? elem_t'(MAX_ELEMENTS) :
			element_count;
		e_in_rng = (e_q != '0) && (e_q <= elem_t'(MAX_ELEMENTS));
		r_ok     = (r_q != '0) && (r_q <= live_q);
		e_act    = e_in_rng && ((a_rdata.prev != '0) || (a_rdata.next != '0));
		sw_last  = (sw_q == addr_t'(DEPTH - 1));
		sw_v     = elem_t'(sw_q);
		sw_in    = (sw_v != '0) && (sw_v <= n_q);
	end

	// Entry written at the sweep address: a straight chain over 1..n, zero elsewhere.
	always_comb begin
		sw_link = '0;
		if (sw_in) begin
			sw_link.prev = (sw_v == elem_t'(1)) ? sw_v : sw_v - elem_t'(1);
			sw_link.next = (sw_v == n_q) ? sw_v : sw_v + elem_t'(1);
			sw_link.rank = sw_v;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sw_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_RESTART) begin
						state_d = ST_SWEEP;
					end else if (cmd == CMD_DEACT) begin
						state_d = ST_DE_RD;
					end else begin
						state_d = ST_RPT_RD;
					end
				end
			end
			ST_SWEEP: begin
				if (sw_last) begin
					state_d = ST_RPT_RD;
				end
			end
			ST_DE_RD: state_d = ST_DE_CHK;
			ST_DE_CHK: begin
				if (!e_act) begin
					state_d = ST_RPT_RD;
				end else if (a_rdata.prev != e_q) begin
					state_d = ST_P_RD;
				end else if (a_rdata.rank == live_q) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_P_RD: state_d = ST_P_WR;
			ST_P_WR: state_d = (rk_q == old_q) ? ST_FLUSH : ST_WALK;
			ST_WALK: state_d = (i_q == old_q) ? ST_WTAIL : ST_WALK;
			ST_WTAIL: state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_RPT_RD;
			ST_RPT_RD: state_d = ST_RPT;
			ST_RPT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory requests and handshake outputs.
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		rslt_valid = 1'b0;
		a_rd       = '0;
		a_wr       = '0;
		b_rd       = '0;
		b_wr       = '0;
		unique case (state_q)
			ST_CLEAR, ST_SWEEP: begin
				a_wr.en   = 1'b1;
				a_wr.addr = sw_q;
				a_wr.data = sw_link;
				b_wr.en   = 1'b1;
				b_wr.addr = sw_q;
				b_wr.data = sw_in ? sw_v : '0;
			end
			ST_DE_RD: begin
				a_rd.en   = 1'b1;
				a_rd.addr = e_in_rng ? to_addr(e_q) : '0;
			end
			ST_DE_CHK: begin
				// Unlink the element itself.
				a_wr.en   = e_act;
				a_wr.addr = to_addr(e_q);
			end
			ST_P_RD: begin
				a_rd.en   = 1'b1;
				a_rd.addr = to_addr(p_q);
			end
			ST_P_WR: begin
				// The predecessor now points past the removed element.
				a_wr.en        = 1'b1;
				a_wr.addr      = to_addr(p_q);
				a_wr.data.prev = a_rdata.prev;
				a_wr.data.next = (s_q == e_q) ? p_q : s_q;
				a_wr.data.rank = a_rdata.rank;
			end
			ST_WALK: begin
				b_rd.en   = 1'b1;
				b_rd.addr = to_addr(i_q);
			end
			ST_FLUSH: begin
				// The last shifted element becomes its own successor.
				a_wr.en        = have_q;
				a_wr.addr      = to_addr(cur_q);
				a_wr.data.prev = curprev_q;
				a_wr.data.next = cur_q;
				a_wr.data.rank = cur_rank_q;
				b_wr.en        = 1'b1;
				b_wr.addr      = to_addr(old_q);
			end
			ST_RPT_RD: begin
				a_rd.en   = 1'b1;
				a_rd.addr = e_in_rng ? to_addr(e_q) : '0;
				b_rd.en   = 1'b1;
				b_rd.addr = r_ok ? to_addr(r_q) : '0;
			end
			ST_RPT: rslt_valid = 1'b1;
			default: ;
		endcase

		// Rank walk: each element read moves one rank down, and the one before it
		// is written back with its successor now known.
		if (rd_vld_s1) begin
			b_wr.en   = 1'b1;
			b_wr.addr = to_addr(rd_idx_s1 - elem_t'(1));
			b_wr.data = b_rdata;
			if (have_q) begin
				a_wr.en        = 1'b1;
				a_wr.addr      = to_addr(cur_q);
				a_wr.data.prev = curprev_q;
				a_wr.data.next = b_rdata;
				a_wr.data.rank = cur_rank_q;
			end
		end
	end

	// Result fields from the registered memory reads.
	always_comb begin
		rslt.element_active  = e_act;
		rslt.predecessor     = e_act ? a_rdata.prev : '0;
		rslt.successor       = e_act ? a_rdata.next : '0;
		rslt.has_predecessor = e_act && (a_rdata.prev != e_q);
		rslt.has_successor   = e_act && (a_rdata.next != e_q);
		rslt.element_rank    = e_act ? a_rdata.rank : '0;
		rslt.first_active    = head_q;
		rslt.active_total    = live_q;
		rslt.element_at_rank = r_ok ? b_rdata : '0;
		rslt.error           = err_q;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: sweep counter, list head, count and walk flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q      <= '0;
			n_q       <= '0;
			head_q    <= '0;
			live_q    <= '0;
			have_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_WALK);
			if (rd_vld_s1) begin
				have_q <= 1'b1;
			end
			unique case (state_q)
				ST_CLEAR, ST_SWEEP: begin
					sw_q <= sw_last ? '0 : sw_q + addr_t'(1);
				end
				ST_IDLE: begin
					if (accept && (cmd == CMD_RESTART)) begin
						n_q    <= cnt_sat;
						head_q <= (cnt_sat != '0) ? elem_t'(1) : '0;
						live_q <= cnt_sat;
					end
				end
				ST_DE_CHK: begin
					if (e_act) begin
						live_q <= live_q - elem_t'(1);
						have_q <= 1'b0;
						if (a_rdata.prev == e_q) begin
							head_q <= (a_rdata.next == e_q) ? '0 : a_rdata.next;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= i_q;
		if (rd_vld_s1) begin
			curprev_q  <= have_q ? cur_q : ((p_q == e_q) ? b_rdata : p_q);
			cur_q      <= b_rdata;
			cur_rank_q <= rd_idx_s1 - elem_t'(1);
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					e_q   <= element;
					r_q   <= rank_index;
					err_q <= 1'b0;
				end
			end
			ST_DE_CHK: begin
				if (!e_act) begin
					err_q <= 1'b1;
				end else begin
					p_q   <= a_rdata.prev;
					s_q   <= a_rdata.next;
					rk_q  <= a_rdata.rank;
					old_q <= live_q;
					i_q   <= a_rdata.rank + elem_t'(1);
				end
			end
			ST_WALK: i_q <= i_q + elem_t'(1);
			default: ;
		endcase
	end

endmodule

// File: rtl/active_set_rank_list.sv
`timescale 1ns / 1ps

// Ascending active set of elements 1..1024 kept as a doubly linked list with
// dense ranks, held in two single-port-read RAMs (links and rank per element,
// element per rank). After reset a clearing pass over every RAM entry runs
// before the first command transfer is taken; configuration writes are taken
// at any time. A restart runs a sweep that writes one entry of both RAMs per
// cycle. An accepted deactivate walks the elements ranked after the removed
// one, reading one rank entry per cycle. The result sits in an output register,
// so the next command transfer can be taken while the previous result waits.
module active_set_rank_list (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  asrl_pkg::elem_t       cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            cmd,
	input  asrl_pkg::elem_t       element,
	input  asrl_pkg::elem_t       rank_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  element_active,
	output asrl_pkg::elem_t       predecessor,
	output asrl_pkg::elem_t       successor,
	output logic                  has_predecessor,
	output logic                  has_successor,
	output asrl_pkg::elem_t       element_rank,
	output asrl_pkg::elem_t       first_active,
	output asrl_pkg::elem_t       active_total,
	output asrl_pkg::elem_t       element_at_rank,
	output logic                  error
);

	import asrl_pkg::*;

	elem_t   element_count_q;
	logic    out_valid_q;
	result_t out_q;
	logic    slot_free;
	logic    rslt_valid;
	result_t rslt;
	rd_req_t a_rd, b_rd;
	a_wr_t   a_wr;
	b_wr_t   b_wr;
	link_t   a_rdata;
	elem_t   b_rdata;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
		end else if (cfg_valid) begin
			element_count_q <= cfg_data;
		end
	end

	// Command sequencer.
	asrl_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.element      (element),
		.rank_index   (rank_index),
		.element_count(element_count_q),
		.slot_free    (slot_free),
		.rslt_valid   (rslt_valid),
		.rslt         (rslt),
		.a_rd         (a_rd),
		.a_wr         (a_wr),
		.a_rdata      (a_rdata),
		.b_rd         (b_rd),
		.b_wr         (b_wr),
		.b_rdata      (b_rdata)
	);

	// Links and rank, indexed by element.
	asrl_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_link_ram (
		.clk  (clk),
		.we   (a_wr.en),
		.waddr(a_wr.addr),
		.wdata(a_wr.data),
		.re   (a_rd.en),
		.raddr(a_rd.addr),
		.rdata(a_rdata)
	);

	// Element, indexed by rank.
	asrl_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_rank_ram (
		.clk  (clk),
		.we   (b_wr.en),
		.waddr(b_wr.addr),
		.wdata(b_wr.data),
		.re   (b_rd.en),
		.raddr(b_rd.addr),
		.rdata(b_rdata)
	);

	// Output register: loads when empty or when its result is transferred.
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= rslt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rslt_valid && slot_free) begin
			out_q <= rslt;
		end
	end

	assign out_valid       = out_valid_q;
	assign element_active  = out_q.element_active;
	assign predecessor     = out_q.predecessor;
	assign successor       = out_q.successor;
	assign has_predecessor = out_q.has_predecessor;
	assign has_successor   = out_q.has_successor;
	assign element_rank    = out_q.element_rank;
	assign first_active    = out_q.first_active;
	assign active_total    = out_q.active_total;
	assign element_at_rank = out_q.element_at_rank;
	assign error           = out_q.error;

endmodule

// File: rtl/asrl_chk.sv
`timescale 1ns / 1ps
`include "active_set_rank_list_macros.svh"

module asrl_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_ready,
	input logic            element_active,
	input asrl_pkg::elem_t predecessor,
	input asrl_pkg::elem_t successor,
	input logic            has_predecessor,
	input logic            has_successor,
	input asrl_pkg::elem_t element_rank,
	input asrl_pkg::elem_t first_active,
	input asrl_pkg::elem_t active_total,
	input asrl_pkg::elem_t element_at_rank,
	input logic            error
);

	import asrl_pkg::*;

	result_t out_word;
	logic    links_ok;
	logic    empty_ok;
	logic    quiet_ok;

	// The result fields as one word, and the conditions the checks below use.
	assign out_word = {element_active, predecessor, successor, has_predecessor, has_successor,
		element_rank, first_active, active_total, element_at_rank, error};
	assign links_ok = (predecessor != '0) && (successor != '0) && (element_rank != '0) &&
		(element_rank <= active_total);
	assign empty_ok = (first_active == '0) && (element_at_rank == '0);
	assign quiet_ok = !element_active && !has_predecessor && !has_successor;

	// A result that is not transferred stays, unchanged.
	`ASRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

	// The count never exceeds the element space.
	`ASRL_ASSERT_NOW(a_total_range, out_valid, active_total <= elem_t'(MAX_ELEMENTS))

	// An active element has both links and a rank within the count.
	`ASRL_ASSERT_NOW(a_active_fields, out_valid && element_active, links_ok)

	// An empty set has no head and no element at any rank.
	`ASRL_ASSERT_NOW(a_empty_set, out_valid && (active_total == '0), empty_ok)

	// A rejected deactivate leaves the element inactive.
	`ASRL_ASSERT_NOW(a_error_inactive, out_valid && error, quiet_ok)

endmodule

bind active_set_rank_list asrl_chk u_asrl_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.element_active (element_active),
	.predecessor    (predecessor),
	.successor      (successor),
	.has_predecessor(has_predecessor),
	.has_successor  (has_successor),
	.element_rank   (element_rank),
	.first_active   (first_active),
	.active_total   (active_total),
	.element_at_rank(element_at_rank),
	.error          (error)
);

// File: sim/asrl_checker.sv
`timescale 1ns / 1ps

// Watches the configuration, command and result channels of the active set
// block. It keeps its own copy of the linked list, the rank tables and the
// restart count, works out the result of every command transfer and checks
// each result transfer against the oldest one still waiting.
module asrl_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  asrl_pkg::elem_t cfg_data,
	input  logic            in_valid,
	input  logic            in_ready,
	input  logic [1:0]      cmd,
	input  asrl_pkg::elem_t element,
	input  asrl_pkg::elem_t rank_index,
	input  logic            out_valid,
	input  logic            out_ready,
	input  logic            element_active,
	input  asrl_pkg::elem_t predecessor,
	input  asrl_pkg::elem_t successor,
	input  logic            has_predecessor,
	input  logic            has_successor,
	input  asrl_pkg::elem_t element_rank,
	input  asrl_pkg::elem_t first_active,
	input  asrl_pkg::elem_t active_total,
	input  asrl_pkg::elem_t element_at_rank,
	input  logic            error,
	output int              mismatches,
	output int              pending,
	output int              checked
);
	import asrl_pkg::*;

	localparam int PRINT_CAP = 40;

	// Own copy of the list: slot 0 of succ_of is the head pointer.
	int unsigned pred_of [0:MAX_ELEMENTS];
	int unsigned succ_of [0:MAX_ELEMENTS];
	int unsigned rank_by_elem [0:MAX_ELEMENTS];
	int unsigned elem_by_rank [0:MAX_ELEMENTS];
	int unsigned live_total;
	int unsigned fill_count;

	result_t expected_q[$];
	result_t seen;
	int      fault_count;
	int      result_count;

	assign seen = {element_active, predecessor, successor, has_predecessor, has_successor,
		element_rank, first_active, active_total, element_at_rank, error};
	assign mismatches = fault_count;

	// Every failure goes through here: one count each, and one line up to the print cap.
	task automatic report_fault(input string msg);
		fault_count++;
		if (fault_count <= PRINT_CAP)
			$display("[%0t] asrl_checker: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int unsigned got,
		input int unsigned want);
		if (got != want)
			report_fault($sformatf("result %0d field %s: got %0d, expected %0d",
				result_count, name, got, want));
	endtask

	function automatic bit in_span(input int unsigned e);
		return e >= 1 && e <= MAX_ELEMENTS;
	endfunction

	// An element is in the set when it is in range and has a nonzero link.
	function automatic bit is_live(input int unsigned e);
		if (!in_span(e))
			return 1'b0;
		return !(pred_of[e] == 0 && succ_of[e] == 0);
	endfunction

	task automatic wipe();
		for (int i = 0; i <= MAX_ELEMENTS; i++) begin
			pred_of[i] = 0;
			succ_of[i] = 0;
			rank_by_elem[i] = 0;
			elem_by_rank[i] = 0;
		end
		live_total = 0;
	endtask

	// Restart: elements 1..n in order, with n saturated at the table size.
	task automatic refill();
		int unsigned n;
		n = (fill_count > MAX_ELEMENTS) ? MAX_ELEMENTS : fill_count;
		wipe();
		if (n == 0)
			return;
		succ_of[0] = 1;
		for (int unsigned i = 1; i <= n; i++) begin
			pred_of[i] = (i == 1) ? i : i - 1;
			succ_of[i] = (i == n) ? i : i + 1;
			rank_by_elem[i] = i;
			elem_by_rank[i] = i;
		end
		live_total = n;
	endtask

	// Remove one live element and close the gap it leaves in the ranks.
	task automatic unlink(input int unsigned e);
		int unsigned p;
		int unsigned s;
		int unsigned old_total;
		int unsigned x;
		p = pred_of[e];
		s = succ_of[e];
		old_total = live_total;
		if (p == e && s == e) begin
			succ_of[0] = 0;
		end else if (p == e) begin
			succ_of[0] = s;
			if (s <= MAX_ELEMENTS)
				pred_of[s] = s;
		end else if (s == e) begin
			if (p <= MAX_ELEMENTS)
				succ_of[p] = p;
		end else begin
			if (s <= MAX_ELEMENTS)
				pred_of[s] = p;
			if (p <= MAX_ELEMENTS)
				succ_of[p] = s;
		end
		pred_of[e] = 0;
		succ_of[e] = 0;
		rank_by_elem[e] = 0;

		// Every element above the removed one moves down one rank.
		for (int unsigned i = 1; i <= old_total && i <= MAX_ELEMENTS; i++) begin
			x = elem_by_rank[i];
			if (x > e && x <= MAX_ELEMENTS) begin
				elem_by_rank[i - 1] = x;
				rank_by_elem[x] = i - 1;
			end
		end
		if (old_total >= 1 && old_total <= MAX_ELEMENTS)
			elem_by_rank[old_total] = 0;
		elem_by_rank[0] = 0;
		if (live_total > 0)
			live_total--;
	endtask

	// Apply one command to the copy and work out the report it gives.
	task automatic predict_report(input cmd_t op, input int unsigned e,
		input int unsigned r, output result_t res);
		bit rejected;
		bit live;
		rejected = 1'b0;
		case (op)
		CMD_RESTART: begin
			refill();
		end
		CMD_DEACT: begin
			if (is_live(e))
				unlink(e);
			else
				rejected = 1'b1;
		end
		default: begin
		end
		endcase

		live = is_live(e);
		res.element_active  = live;
		res.predecessor     = live ? elem_t'(pred_of[e]) : '0;
		res.successor       = live ? elem_t'(succ_of[e]) : '0;
		res.has_predecessor = live && pred_of[e] != e;
		res.has_successor   = live && succ_of[e] != e;
		res.element_rank    = live ? elem_t'(rank_by_elem[e]) : '0;
		res.first_active    = elem_t'(succ_of[0]);
		res.active_total    = elem_t'(live_total);
		res.element_at_rank = (r >= 1 && r <= live_total && r <= MAX_ELEMENTS) ?
			elem_t'(elem_by_rank[r]) : '0;
		res.error           = rejected;
	endtask

	task automatic compare_report(input result_t got, input result_t want);
		check_field("element_active", got.element_active, want.element_active);
		check_field("predecessor", got.predecessor, want.predecessor);
		check_field("successor", got.successor, want.successor);
		check_field("has_predecessor", got.has_predecessor, want.has_predecessor);
		check_field("has_successor", got.has_successor, want.has_successor);
		check_field("element_rank", got.element_rank, want.element_rank);
		check_field("first_active", got.first_active, want.first_active);
		check_field("active_total", got.active_total, want.active_total);
		check_field("element_at_rank", got.element_at_rank, want.element_at_rank);
		check_field("error", got.error, want.error);
	endtask

	// Sample all three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			wipe();
			fill_count = 0;
			expected_q.delete();
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				fill_count = cfg_data;

			// A result transfer is checked before a new command joins the queue.
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_fault($sformatf("result %0d arrived with no command outstanding",
						result_count));
				end else begin
					want = expected_q.pop_front();
					compare_report(seen, want);
				end
				result_count++;
			end

			if (in_valid && in_ready) begin
				predict_report(cmd_t'(cmd), element, rank_index, fresh);
				expected_q.push_back(fresh);
			end

			pending <= expected_q.size();
			checked <= result_count;
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

// Drives the active set block with a directed opening and then random phases:
// each phase sets the restart count, restarts, then mixes deactivates,
// queries, restarts and the spare code. The checker does all prediction.
module tb;
	import asrl_pkg::*;

	localparam int unsigned FIELD_TOP = 2047;
	localparam int          ITEM_GOAL = 570;

	typedef enum int {
		RX_OPEN,
		RX_CHOPPY,
		RX_LONG
	} rx_mode_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	elem_t      cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] cmd;
	elem_t      element;
	elem_t      rank_index;
	logic       out_valid;
	logic       out_ready;
	logic       element_active;
	elem_t      predecessor;
	elem_t      successor;
	logic       has_predecessor;
	logic       has_successor;
	elem_t      element_rank;
	elem_t      first_active;
	elem_t      active_total;
	elem_t      element_at_rank;
	logic       error;

	int mismatches;
	int pending;
	int checked;

	// Stimulus bookkeeping: which elements the sender believes are live.
	int unsigned live_q[$];
	int unsigned fill_setting;
	int          burst_left;
	int          items_sent;
	int          n_restart;
	int          n_query;
	int          n_deact;
	int          n_spare;
	int          n_cfg;

	// Receiver pacing state.
	rx_mode_t stall_mode;
	int       mode_left;
	int       hold_left;

	active_set_rank_list dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.element         (element),
		.rank_index      (rank_index),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.element_active  (element_active),
		.predecessor     (predecessor),
		.successor       (successor),
		.has_predecessor (has_predecessor),
		.has_successor   (has_successor),
		.element_rank    (element_rank),
		.first_active    (first_active),
		.active_total    (active_total),
		.element_at_rank (element_at_rank),
		.error           (error)
	);

	asrl_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.element         (element),
		.rank_index      (rank_index),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.element_active  (element_active),
		.predecessor     (predecessor),
		.successor       (successor),
		.has_predecessor (has_predecessor),
		.has_successor   (has_successor),
		.element_rank    (element_rank),
		.first_active    (first_active),
		.active_total    (active_total),
		.element_at_rank (element_at_rank),
		.error           (error),
		.mismatches      (mismatches),
		.pending         (pending),
		.checked         (checked)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// The receiver switches between always ready, choppy and long stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_mode = RX_OPEN;
			mode_left = 0;
			hold_left = 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (stall_mode)
			RX_OPEN: begin
				out_ready <= 1'b1;
			end
			RX_CHOPPY: begin
				out_ready <= ($urandom_range(0, 99) < 60);
			end
			default: begin
				if (hold_left > 0) begin
					hold_left--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 3) == 0)
						hold_left = $urandom_range(5, 40);
				end
			end
			endcase
		end
	end

	// Write the restart count; only called while nothing is in flight.
	task automatic put_reg(input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_data <= elem_t'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		fill_setting = value;
		n_cfg++;
	endtask

	// Stop sending and wait until every result has been transferred.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	// One command transfer, with a random gap between bursts.
	task automatic issue(input cmd_t op, input int unsigned e, input int unsigned r);
		int gap;
		int roll;
		int unsigned n;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			roll = $urandom_range(0, 19);
			if (roll < 6)
				gap = 0;
			else if (roll < 18)
				gap = $urandom_range(1, 8);
			else
				gap = $urandom_range(20, 60);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= op;
		element <= elem_t'(e);
		rank_index <= elem_t'(r);
		do @(posedge clk); while (!in_ready);
		items_sent++;

		// Track the live set so that later picks hit real elements.
		case (op)
		CMD_RESTART: begin
			n_restart++;
			live_q.delete();
			n = (fill_setting > MAX_ELEMENTS) ? MAX_ELEMENTS : fill_setting;
			for (int unsigned i = 1; i <= n; i++)
				live_q.push_back(i);
		end
		CMD_DEACT: begin
			n_deact++;
			for (int i = 0; i < live_q.size(); i++) begin
				if (live_q[i] == e) begin
					live_q.delete(i);
					break;
				end
			end
		end
		CMD_QUERY: begin
			n_query++;
		end
		default: begin
			n_spare++;
		end
		endcase
	endtask

	// Mostly live elements, some near the filled range, a few anywhere.
	function automatic int unsigned pick_element(input int unsigned span);
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6 && live_q.size() > 0)
			return live_q[$urandom_range(0, live_q.size() - 1)];
		if (roll < 9)
			return $urandom_range(0, span + 2);
		return $urandom_range(0, FIELD_TOP);
	endfunction

	function automatic int unsigned pick_rank();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, FIELD_TOP);
		return $urandom_range(0, live_q.size() + 2);
	endfunction

	initial begin : stimulus
		int unsigned setting;
		int unsigned span;
		int          steps;
		int          roll;
		int          kind;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_QUERY;
		element <= '0;
		rank_index <= '0;
		fill_setting = 0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty set straight after reset.
		issue(CMD_QUERY, 0, 0);
		issue(CMD_DEACT, 1, 0);
		drain();

		// Five elements: ends, middle, head slot, out of range and spare code.
		put_reg(5);
		issue(CMD_RESTART, 3, 5);
		issue(CMD_QUERY, 1, 1);
		issue(CMD_QUERY, 5, 6);
		issue(CMD_QUERY, 6, 0);
		issue(CMD_QUERY, 0, 3);
		issue(CMD_SPARE, 2, 2);
		issue(CMD_QUERY, FIELD_TOP, FIELD_TOP);
		issue(CMD_DEACT, 3, 3);
		issue(CMD_DEACT, 1, 1);
		issue(CMD_DEACT, 5, 2);
		issue(CMD_DEACT, 3, 1);
		issue(CMD_DEACT, 0, 1);
		issue(CMD_DEACT, 1025, 2);
		issue(CMD_DEACT, FIELD_TOP, 1024);
		issue(CMD_DEACT, 2, 1);
		issue(CMD_DEACT, 4, 1);
		issue(CMD_QUERY, 4, 1);
		drain();

		// A restart with a zero count leaves the set empty.
		put_reg(0);
		issue(CMD_RESTART, 1, 1);
		drain();

		// An oversized count saturates; remove the lowest to force a full walk.
		put_reg(FIELD_TOP);
		issue(CMD_RESTART, 1024, 1024);
		issue(CMD_QUERY, 1024, 1024);
		issue(CMD_DEACT, 1, 1023);
		issue(CMD_DEACT, 1024, 1022);
		issue(CMD_QUERY, 1023, 1022);

		// Random phases, each opened by a register write and a restart.
		while (items_sent < ITEM_GOAL) begin
			drain();
			kind = $urandom_range(0, 99);
			if (kind < 6)
				setting = $urandom_range(1024, FIELD_TOP);
			else if (kind < 12)
				setting = $urandom_range(0, 2);
			else
				setting = $urandom_range(3, 40);
			span = (setting > MAX_ELEMENTS) ? MAX_ELEMENTS : setting;
			put_reg(setting);
			issue(CMD_RESTART, pick_element(span), pick_rank());

			steps = (setting > 40) ? $urandom_range(4, 10) : $urandom_range(8, 40);
			repeat (steps) begin
				roll = $urandom_range(0, 99);
				if (roll < 45) begin
					if (live_q.size() > 0)
						issue(CMD_DEACT, live_q[$urandom_range(0, live_q.size() - 1)],
							pick_rank());
					else
						issue(CMD_DEACT, pick_element(span), pick_rank());
				end else if (roll < 55) begin
					if ($urandom_range(0, 1) == 1)
						issue(CMD_DEACT, $urandom_range(0, FIELD_TOP), pick_rank());
					else
						issue(CMD_DEACT, $urandom_range(0, span + 3), pick_rank());
				end else if (roll < 88) begin
					issue(CMD_QUERY, pick_element(span), pick_rank());
				end else if (roll < 93) begin
					issue(CMD_SPARE, pick_element(span), pick_rank());
				end else if (roll < 97) begin
					issue(CMD_RESTART, pick_element(span), pick_rank());
				end else begin
					// Let the pipeline run completely dry mid-phase.
					drain();
				end
			end
		end

		drain();
		repeat (60) @(posedge clk);

		$display("Run covered %0d commands: %0d restarts, %0d queries, %0d deactivates, %0d spare.",
			items_sent, n_restart, n_query, n_deact, n_spare);
		$display("Restart count written %0d times; %0d results compared.", n_cfg, checked);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
